// ===== rtl/mmvs_pkg.sv =====
// ----------------------------------------------------------------------------
// mmvs_pkg
// Shared types and constants for the matrix median value search unit.
// ----------------------------------------------------------------------------
package mmvs_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned LoW      = DataW + 1;
  localparam int unsigned PaddrW   = 3;

  localparam logic [DataW-1:0]  UpperBoundRst = 16'd2000;
  localparam logic [PaddrW-1:0] RegUpperBound = 3'd0;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_INIT,
    ST_SCAN,
    ST_TAIL,
    ST_DECIDE,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/matrix_median_value_search_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_median_value_search_unit
// Stores a row-sorted matrix word by word and finds its median by a binary
// search on value, counting stored elements below each trial value.
// ----------------------------------------------------------------------------
// usage
//   slave stream: one element per word in tdata, tlast on the final element.
//   loading takes one word per cycle; tready is high while loading.
//   the tlast word is stored too (if room) and starts the search over the
//   range 0 .. search_upper_bound (apb register at byte address 0).
//   each search pass for n stored elements picks the trial value, makes
//   n reads through the single read port, takes in the last read data and
//   narrows the range; at most ceil(log2(bound + 2)) passes run, and from
//   the tlast word no word is taken until the result enters the output
//   register.
//   master stream: one word, the median, per frame. it sits in an output
//   register; loading of the next frame goes on while it waits, and a
//   finished search holds until the register is free.
//   reset clears the counts, the output valid and sets the bound to 2000.
//   elements beyond MAX_ELEMENTS in one frame are dropped.
// ----------------------------------------------------------------------------
module matrix_median_value_search_unit
  import mmvs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned VALUE_BITS   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DataW-1:0]  s_axis_tdata_i,   // [15:0] element_value
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DataW-1:0]  m_axis_tdata_o,   // [15:0] median_value
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  localparam int unsigned NW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = (VALUE_BITS > DataW) ? VALUE_BITS : DataW;
  localparam logic [NW-1:0] MaxCount = NW'(MAX_ELEMENTS);

  state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mem_q [MAX_ELEMENTS];
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  rvld_q;

  logic [DataW-1:0] upper_q;
  logic [NW-1:0]    n_q;
  logic [NW-1:0]    idx_q;
  logic [NW-1:0]    cnt_q;
  logic [LoW-1:0]   lo_q;
  logic [DataW-1:0] hi_q;
  logic [DataW-1:0] mid_q;
  logic [DataW-1:0] best_q;
  logic             out_vld_q;
  logic [DataW-1:0] out_data_q;

  logic             s_acc;
  logic             cfg_wr;
  logic             rd_en;
  logic [CW-1:0]    elem_ext;
  logic [LoW:0]     mid_sum;
  logic             out_free;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign elem_ext = CW'(s_axis_tdata_i);
  assign mid_sum  = (LoW + 1)'(lo_q) + (LoW + 1)'(hi_q);
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign rd_en    = (state_q == ST_SCAN);

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i == RegUpperBound) ? 32'(upper_q) : 32'd0;

  // element memory
  always_ff @(posedge clk_i) begin
    if (s_acc && (n_q < MaxCount)) begin
      mem_q[n_q[AW-1:0]] <= elem_ext[VALUE_BITS-1:0];
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (s_acc && s_axis_tlast_i) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (lo_q > LoW'(hi_q))   state_d = ST_EMIT;
        else if (n_q == '0)      state_d = ST_DECIDE;
        else                     state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_q == n_q - NW'(1)) state_d = ST_TAIL;
      end
      ST_TAIL:   state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_INIT;
      ST_EMIT: begin
        if (out_free) state_d = ST_LOAD;
      end
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      upper_q    <= UpperBoundRst;
      n_q        <= '0;
      idx_q      <= '0;
      cnt_q      <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      best_q     <= '0;
      rvld_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      out_data_q <= '0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rd_en;
      if (cfg_wr && (paddr_i == RegUpperBound)) begin
        upper_q <= pwdata_i[DataW-1:0];
      end
      if (out_vld_q && m_axis_tready_i && (state_q != ST_EMIT)) begin
        out_vld_q <= 1'b0;
      end
      if (rvld_q && (CW'(rdata_q) < CW'(mid_q))) begin
        cnt_q <= cnt_q + NW'(1);
      end
      unique case (state_q)
        ST_LOAD: begin
          if (s_acc) begin
            if (n_q < MaxCount) n_q <= n_q + NW'(1);
            if (s_axis_tlast_i) begin
              lo_q <= '0;
              hi_q <= upper_q;
            end
          end
        end
        ST_INIT: begin
          mid_q <= mid_sum[DataW:1];
          cnt_q <= '0;
          idx_q <= '0;
        end
        ST_SCAN: begin
          idx_q <= idx_q + NW'(1);
        end
        ST_DECIDE: begin
          if (cnt_q <= (n_q >> 1)) begin
            best_q <= mid_q;
            lo_q   <= LoW'(mid_q) + LoW'(1);
          end else begin
            hi_q <= mid_q - DataW'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_data_q <= best_q;
            n_q        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MaxCount)
    else $error("element count above capacity");

  a_decide_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (lo_q <= LoW'(hi_q)))
    else $error("trial value outside search range");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> (state_q == ST_INIT && n_q != '0 || state_q == ST_INIT))
    else $error("last word did not start a search");

  a_read_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> (state_q == ST_SCAN || state_q == ST_TAIL))
    else $error("read data outside scan");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |-> (best_q <= upper_q))
    else $error("median above search bound");
`endif

endmodule

// ===== verif/matrix_median_value_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// matrix_median_value_search_unit_tb
// Streams row-sorted matrices into the median search unit under several
// search bounds and compares every median word against a behavioral search.
// Includes single-element frames and zero and full-range bounds.
// Random idling is applied on both streams.
// ----------------------------------------------------------------------------
module matrix_median_value_search_unit_tb;
  import mmvs_pkg::*;

  localparam int unsigned StoreDepth = 1024;

  class median_tracker;
    logic [DataW-1:0] element_mem [StoreDepth];
    int unsigned      fill;
    logic [DataW-1:0] upper_bound;
    logic [DataW-1:0] expected_medians [$];
    int unsigned      fail_count;
    int unsigned      medians_checked;
    int unsigned      words_seen;
    int unsigned      frames_seen;

    function new();
      fill            = 0;
      upper_bound     = UpperBoundRst;
      fail_count      = 0;
      medians_checked = 0;
      words_seen      = 0;
      frames_seen     = 0;
    endfunction

    function int unsigned count_below(int unsigned trial);
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < fill; i++) begin
        if (element_mem[i] < trial) n++;
      end
      return n;
    endfunction

    function logic [DataW-1:0] search_median();
      int               lo;
      int               hi;
      int               mid;
      int unsigned      half;
      logic [DataW-1:0] best;
      lo   = 0;
      hi   = int'(upper_bound);
      half = fill / 2;
      best = '0;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (count_below(mid) <= half) begin
          best = mid[DataW-1:0];
          lo   = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      return best;
    endfunction

    function void note_element(logic [DataW-1:0] value, bit is_last);
      words_seen++;
      if (fill < StoreDepth) begin
        element_mem[fill] = value;
        fill++;
      end
      if (is_last) begin
        expected_medians.push_back(search_median());
        fill = 0;
        frames_seen++;
      end
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 40) $display("mismatch: %s", msg);
    endtask

    task check_median(logic [DataW-1:0] got);
      logic [DataW-1:0] want;
      if (expected_medians.size() == 0) begin
        report_mismatch($sformatf("median %0d with no frame pending", got));
        return;
      end
      want = expected_medians.pop_front();
      medians_checked++;
      if (got !== want) begin
        report_mismatch($sformatf("median got %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_n;
  logic              s_axis_tvalid;
  logic              s_axis_tready_o;
  logic [DataW-1:0]  s_axis_tdata;   // [15:0] element_value
  logic              s_axis_tlast;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready;
  logic [DataW-1:0]  m_axis_tdata_o; // [15:0] median_value
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata_o;
  logic              pready_o;

  median_tracker tracker = new();
  bit            idle_on;

  always #5 clk_i = ~clk_i;

  matrix_median_value_search_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  // one element word, with an optional gap before it
  task automatic send_word(logic [DataW-1:0] value, bit is_last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_element(value, is_last);
  endtask

  // stop sending and let every pending median come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.expected_medians.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic check_bound_reg(logic [DataW-1:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= RegUpperBound;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata_o[DataW-1:0] !== want) begin
      tracker.report_mismatch($sformatf("bound reads %0d, expected %0d",
                                        prdata_o[DataW-1:0], want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_bound(logic [DataW-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RegUpperBound;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    tracker.upper_bound = value;
    check_bound_reg(value);
  endtask

  task automatic send_list(logic [DataW-1:0] values [$]);
    foreach (values[i]) send_word(values[i], i == values.size() - 1);
  endtask

  // rows ascending with random content; some frames are unsorted noise
  task automatic send_matrix();
    int          rows;
    int          cols;
    int          kind;
    int          span;
    int          acc;
    int          step;
    logic [DataW-1:0] value;
    rows = $urandom_range(1, 5);
    cols = $urandom_range(1, 6);
    kind = $urandom_range(0, 9);
    span = (kind < 7) ? int'(tracker.upper_bound) + int'(tracker.upper_bound) / 4 + 2
                      : 65536;
    step = span / cols + 1;
    for (int r = 0; r < rows; r++) begin
      acc = $urandom_range(0, span - 1);
      for (int c = 0; c < cols; c++) begin
        if (kind == 9) begin
          value = 16'($urandom_range(0, 65535));
        end else begin
          if (acc > 65535) acc = 65535;
          value = acc[DataW-1:0];
          acc   = acc + $urandom_range(0, step);
        end
        send_word(value, r == rows - 1 && c == cols - 1);
      end
    end
  endtask

  initial begin
    logic [DataW-1:0] bounds [5];
    logic [DataW-1:0] frame [$];
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    idle_on       = 1'b0;
    rst_n         <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset bound
    check_bound_reg(UpperBoundRst);
    frame = '{16'd0};
    send_list(frame);
    frame = '{16'd65535};
    send_list(frame);
    frame = '{16'd1, 16'd5, 16'd9, 16'd2, 16'd3, 16'd7};
    send_list(frame);
    wait_drained();

    // zero bound always gives zero
    write_bound(16'd0);
    frame = '{16'd7, 16'd8, 16'd9};
    send_list(frame);
    wait_drained();

    // full-range bound, extreme and alternating bit patterns
    write_bound(16'd65535);
    frame = '{16'd0, 16'd65535, 16'd1, 16'd65535};
    send_list(frame);
    frame = '{16'h5555, 16'haaaa};
    send_list(frame);
    frame = '{16'haaaa, 16'h5555, 16'hffff};
    send_list(frame);
    wait_drained();

    bounds[0] = 16'd1;
    bounds[1] = 16'd65535;
    bounds[2] = 16'($urandom_range(2, 65534));
    bounds[3] = 16'd300;
    bounds[4] = UpperBoundRst;
    for (int p = 0; p < 5; p++) begin
      write_bound(bounds[p]);
      idle_on = (p < 4);
      for (int start = tracker.words_seen; tracker.words_seen - start < 100; ) begin
        send_matrix();
        if (p == 2 && tracker.words_seen - start >= 50
            && tracker.words_seen - start < 80) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    while (tracker.expected_medians.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (tracker.expected_medians.size() != 0) begin
      tracker.report_mismatch("medians still pending at end of run");
    end
    $display("summary: %0d words in %0d frames, %0d medians checked",
             tracker.words_seen, tracker.frames_seen, tracker.medians_checked);
    $display("summary: bounds 0, 1, 300, 2000, 65535 and %0d",
             bounds[2]);
    if (tracker.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // median side, random stall bursts while idling is on
  initial begin
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready) tracker.check_median(m_axis_tdata_o);
      if (stall > 0) begin
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 8);
      end
      m_axis_tready <= (stall == 0);
    end
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
